// ===== design/mtws_pkg.sv =====
// ----------------------------------------------------------------------------
// mtws_pkg - shared types and constants for the multi-task watchdog
// Opcodes, controller/datapath command and status structs, and sizing helpers.
// ----------------------------------------------------------------------------
package mtws_pkg;

  // Default slot count, register reset value, strike limit and mask width
  localparam int unsigned TASK_SLOTS_DEF = 16;
  localparam logic [31:0] TIMEOUT_RST    = 32'd500;
  localparam logic [1:0]  STRIKE_LIMIT   = 2'd3;
  localparam int unsigned MASK_W         = 16;

  // Config port: one register, byte address 0
  localparam int unsigned ADDR_W       = 3;
  localparam logic [ADDR_W-1:0] ADDR_TIMEOUT = 3'd0;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PET    = 2'd1,
    OP_ENABLE = 2'd2,
    OP_CHECK  = 2'd3
  } op_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the accepted item, clear result
    logic apply;    // single-slot update for tick/pet/enable
    logic rd;       // read the slot at the scan pointer
    logic eval;     // evaluate the slot read last cycle, write back
  } mtws_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_check;  // captured item is a check
    logic last_rd;   // scan pointer is at the last slot
  } mtws_status_t;

  // Slot index width, at least one bit
  function automatic int unsigned idx_w(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== design/mtws_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtws_ctrl - watchdog sequencer
// Accepts one item, runs a single update or a slot-by-slot check sweep, then
// holds the result until it is taken.
// ----------------------------------------------------------------------------
module mtws_ctrl
  import mtws_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  mtws_status_t status_i,
  output mtws_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_e;

  state_e state_q;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_APPLY;
        end
        ST_APPLY: begin
          if (!status_i.is_check) state_q <= ST_DONE;
          else if (status_i.last_rd) state_q <= ST_LAST;
          else state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (status_i.last_rd) state_q <= ST_LAST;
        end
        ST_LAST: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_stall_i) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Commands decoded from state
  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.apply   = (state_q == ST_APPLY) && !status_i.is_check;
    cmd_o.rd      = ((state_q == ST_APPLY) && status_i.is_check) || (state_q == ST_SCAN);
    cmd_o.eval    = (state_q == ST_SCAN) || (state_q == ST_LAST);
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);

endmodule

// ===== design/mtws_dp.sv =====
// ----------------------------------------------------------------------------
// mtws_dp - watchdog slot tables and check datapath
// Holds enable bits, last-active times, strike counts and the kill counter;
// evaluates one slot per cycle during a check.
// ----------------------------------------------------------------------------
module mtws_dp
  import mtws_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtws_cmd_t          cmd_i,
  output mtws_status_t       status_o,
  input  logic [31:0]        timeout_i,
  input  logic [1:0]         op_i,
  input  logic [3:0]         slot_i,
  input  logic               has_current_i,
  input  logic               enable_i,
  input  logic [31:0]        now_i,
  output logic [MASK_W-1:0]  kill_mask_o,
  output logic [MASK_W-1:0]  warn_mask_o,
  output logic               all_ok_o,
  output logic [31:0]        kills_total_o
);

  localparam int unsigned IDX_W = idx_w(TASK_SLOTS);

  // Captured item
  op_e         op_q;
  logic [3:0]  slot_q;
  logic        has_cur_q;
  logic        enable_q;
  logic [31:0] now_q;

  // Slot state: enable and row-written bits in flops, time and strikes in memories
  logic [TASK_SLOTS-1:0] en_q;
  logic [TASK_SLOTS-1:0] row_vld_q;
  logic [31:0]           time_mem [TASK_SLOTS];
  logic [1:0]            strk_mem [TASK_SLOTS];
  logic [31:0]           kill_cnt_q;

  // Scan pointer and read stage
  logic [IDX_W-1:0] rd_idx_q;
  logic [IDX_W-1:0] eval_idx_q;
  logic [31:0]      rd_time_q;
  logic [1:0]       rd_strk_q;
  logic             rd_vld_q;
  logic             rd_en_q;

  // Result
  logic [MASK_W-1:0] kill_mask_q;
  logic [MASK_W-1:0] warn_mask_q;
  logic              all_ok_q;

  // Write port
  logic [IDX_W-1:0] wr_addr;
  logic             time_we;
  logic             strk_we;
  logic [31:0]      time_wd;
  logic [1:0]       strk_wd;
  logic             en_we;

  logic [IDX_W-1:0]  slot_idx;
  logic              cur_valid;
  logic [31:0]       eval_time;
  logic [1:0]        eval_strk;
  logic [1:0]        strk_inc;
  logic [31:0]       elapsed;
  logic              skip;
  logic              over;
  logic              killed;
  logic [MASK_W-1:0] eval_bit;

  assign slot_idx  = IDX_W'(slot_q);
  assign cur_valid = has_cur_q && ({3'b000, slot_q} < 7'(TASK_SLOTS));

  assign status_o.is_check = (op_q == OP_CHECK);
  assign status_o.last_rd  = (rd_idx_q == IDX_W'(TASK_SLOTS - 1));

  // Slot evaluation; a row never written reads as zero
  assign eval_time = rd_vld_q ? rd_time_q : '0;
  assign eval_strk = rd_vld_q ? rd_strk_q : '0;
  assign elapsed   = now_q - eval_time;
  assign skip      = cur_valid && (eval_idx_q == slot_idx);
  assign over      = cmd_i.eval && rd_en_q && !skip && (elapsed > timeout_i);
  assign strk_inc  = (eval_strk == STRIKE_LIMIT) ? STRIKE_LIMIT : eval_strk + 2'd1;
  assign killed    = (strk_inc == STRIKE_LIMIT);
  assign eval_bit  = (7'(eval_idx_q) < 7'(MASK_W)) ? (MASK_W'(1) << eval_idx_q) : '0;

  // Write port mux: check write-back or single-slot update
  always_comb begin
    wr_addr = slot_idx;
    time_we = 1'b0;
    strk_we = 1'b0;
    en_we   = 1'b0;
    time_wd = now_q;
    strk_wd = '0;
    if (cmd_i.eval) begin
      wr_addr = eval_idx_q;
      strk_we = over;
      strk_wd = strk_inc;
      time_we = over && !killed;
    end else if (cmd_i.apply && cur_valid) begin
      case (op_q)
        OP_TICK: begin
          time_we = en_q[slot_idx];
        end
        OP_PET: begin
          time_we = en_q[slot_idx];
          strk_we = en_q[slot_idx];
        end
        OP_ENABLE: begin
          en_we   = 1'b1;
          time_we = enable_q;
          strk_we = enable_q;
        end
        default: begin
          time_we = 1'b0;
        end
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_e'(op_i);
      slot_q    <= slot_i;
      has_cur_q <= has_current_i;
      enable_q  <= enable_i;
      now_q     <= now_i;
    end
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (time_we) time_mem[wr_addr] <= time_wd;
    if (strk_we) strk_mem[wr_addr] <= strk_wd;
  end

  // Registered read at the scan pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_time_q  <= time_mem[rd_idx_q];
      rd_strk_q  <= strk_mem[rd_idx_q];
      rd_vld_q   <= row_vld_q[rd_idx_q];
      rd_en_q    <= en_q[rd_idx_q];
      eval_idx_q <= rd_idx_q;
    end
  end

  // Control state: enables, row valid bits, scan pointer, kill counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= '0;
      row_vld_q  <= '0;
      rd_idx_q   <= '0;
      kill_cnt_q <= '0;
    end else begin
      if (en_we) en_q[wr_addr] <= enable_q;
      if (time_we || strk_we) row_vld_q[wr_addr] <= 1'b1;
      if (cmd_i.capture) rd_idx_q <= '0;
      else if (cmd_i.rd) rd_idx_q <= rd_idx_q + IDX_W'(1);
      if (over && killed) kill_cnt_q <= kill_cnt_q + 32'd1;
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kill_mask_q <= '0;
      warn_mask_q <= '0;
      all_ok_q    <= 1'b1;
    end else if (over) begin
      if (killed) begin
        kill_mask_q <= kill_mask_q | eval_bit;
        all_ok_q    <= 1'b0;
      end else begin
        warn_mask_q <= warn_mask_q | eval_bit;
      end
    end
  end

  assign kill_mask_o   = kill_mask_q;
  assign warn_mask_o   = warn_mask_q;
  assign all_ok_o      = all_ok_q;
  assign kills_total_o = kill_cnt_q;

endmodule

// ===== design/multi_task_watchdog_strikes.sv =====
// A tick, pet or enable item passes through the apply state and then shows
// its result on the output. A check item sweeps the slot table one slot per
// cycle through the time and strike memories: the apply state issues the
// first read, each scan state reads a further slot while evaluating the one
// before, and the last state evaluates the final slot. One item is in flight
// at a time: the input stalls from acceptance until the result has been
// taken, and the next item can be accepted in the cycle after that. Reset
// clears the enable bits, row valid bits and kill counter at once, so no
// clearing pass is needed.
// ----------------------------------------------------------------------------
// multi_task_watchdog_strikes - multi-slot task watchdog with strike counting
// Top level: APB timeout register, sequencer and slot datapath.
// ----------------------------------------------------------------------------
module multi_task_watchdog_strikes
  import mtws_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Item input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  logic [3:0]        slot_i,
  input  logic              has_current_i,
  input  logic              enable_i,
  input  logic [31:0]       now_i,
  // Result output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [MASK_W-1:0] kill_mask_o,
  output logic [MASK_W-1:0] warn_mask_o,
  output logic              all_ok_o,
  output logic [31:0]       kills_total_o,
  // Config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0]  timeout_q;
  mtws_cmd_t    cmd;
  mtws_status_t status;

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
    end else if (psel && penable && pwrite && (paddr == ADDR_TIMEOUT)) begin
      timeout_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TIMEOUT) ? timeout_q : '0;

  mtws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mtws_dp #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .timeout_i     (timeout_q),
    .op_i          (op_i),
    .slot_i        (slot_i),
    .has_current_i (has_current_i),
    .enable_i      (enable_i),
    .now_i         (now_i),
    .kill_mask_o   (kill_mask_o),
    .warn_mask_o   (warn_mask_o),
    .all_ok_o      (all_ok_o),
    .kills_total_o (kills_total_o)
  );

endmodule

// ===== design/mtws_checker.sv =====
// ----------------------------------------------------------------------------
// mtws_checker - port-level checks for the task watchdog
// Watches the item channels and result fields of the top level over time.
// ----------------------------------------------------------------------------
module mtws_checker
  import mtws_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [MASK_W-1:0] kill_mask_o,
  input logic [MASK_W-1:0] warn_mask_o,
  input logic              all_ok_o,
  input logic [31:0]       kills_total_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kill_mask_o)
      && $stable(warn_mask_o) && $stable(kills_total_o))
    else $error("stalled result changed");

  // One item in flight: no accept while a result waits
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  // A freshly accepted item has no result the next cycle
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result too early");

  // A slot is never both killed and warned, and a kill clears all_ok
  a_masks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kill_mask_o & warn_mask_o) == '0)
      && ((kill_mask_o == '0) || !all_ok_o))
    else $error("inconsistent kill/warn result");

endmodule

bind multi_task_watchdog_strikes mtws_checker u_mtws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .kill_mask_o   (kill_mask_o),
  .warn_mask_o   (warn_mask_o),
  .all_ok_o      (all_ok_o),
  .kills_total_o (kills_total_o)
);

// ===== dv/multi_task_watchdog_strikes_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_task_watchdog_strikes_tb - self-checking bench for the task watchdog
// Drives tick, pet, enable and check items through the valid/stall channels.
// A directed table runs first, then random traffic under several timeout settings.
// Each result is compared with a slot-table predictor kept here or a verdict typed in the table.
// ----------------------------------------------------------------------------
module multi_task_watchdog_strikes_tb
  import mtws_pkg::*;
();

  localparam int unsigned NSLOTS      = 16;
  localparam int unsigned PHASE_ITEMS = 300;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 3000;

  typedef struct {
    op_e         op;
    logic [3:0]  slot;
    logic        has_cur;
    logic        en;
    logic [31:0] now;
  } wd_item_t;

  typedef struct {
    logic [MASK_W-1:0] kill;
    logic [MASK_W-1:0] warn;
    logic              ok;
    logic [31:0]       total;
  } wd_verdict_t;

  typedef struct {
    wd_item_t    it;
    logic        fixed;  // verdict typed in below rather than predicted
    wd_verdict_t v;
  } wd_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        op_i;
  logic [3:0]        slot_i;
  logic              has_current_i;
  logic              enable_i;
  logic [31:0]       now_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [MASK_W-1:0] kill_mask_o;
  logic [MASK_W-1:0] warn_mask_o;
  logic              all_ok_o;
  logic [31:0]       kills_total_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // Predictor copy of the slot table and register
  logic        wd_enabled   [NSLOTS];
  logic [31:0] wd_last_tick [NSLOTS];
  logic [1:0]  wd_strikes   [NSLOTS];
  logic [31:0] wd_kill_count;
  logic [31:0] wd_timeout;

  wd_verdict_t pending_verdicts[$];
  wd_row_t     directed_rows[$];

  int unsigned err_count;
  int unsigned n_items;
  int unsigned n_checks;
  int unsigned n_results;
  int unsigned n_kill_bits;
  int unsigned n_warn_bits;
  int unsigned n_settings;
  int unsigned quiet_cycles;
  logic        calm;
  logic        hold_req;

  multi_task_watchdog_strikes u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .slot_i        (slot_i),
    .has_current_i (has_current_i),
    .enable_i      (enable_i),
    .now_i         (now_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kill_mask_o   (kill_mask_o),
    .warn_mask_o   (warn_mask_o),
    .all_ok_o      (all_ok_o),
    .kills_total_o (kills_total_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Mismatch reporting
  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, exp_v, got_v);
    err_count++;
  endtask

  // Slot-table update for one accepted item; returns the verdict it gives
  task automatic predict_watchdog(input wd_item_t it, output wd_verdict_t v);
    logic [31:0] idle_for;
    v.kill  = '0;
    v.warn  = '0;
    v.ok    = 1'b1;
    case (it.op)
      OP_TICK: begin
        if (it.has_cur && wd_enabled[it.slot]) wd_last_tick[it.slot] = it.now;
      end
      OP_PET: begin
        if (it.has_cur && wd_enabled[it.slot]) begin
          wd_last_tick[it.slot] = it.now;
          wd_strikes[it.slot]   = '0;
        end
      end
      OP_ENABLE: begin
        if (it.has_cur) begin
          wd_enabled[it.slot] = it.en;
          if (it.en) begin
            wd_last_tick[it.slot] = it.now;
            wd_strikes[it.slot]   = '0;
          end
        end
      end
      default: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (!wd_enabled[i] || (it.has_cur && i == it.slot)) continue;
          idle_for = it.now - wd_last_tick[i];
          if (idle_for > wd_timeout) begin
            if (wd_strikes[i] < STRIKE_LIMIT) wd_strikes[i] = wd_strikes[i] + 2'd1;
            if (wd_strikes[i] == STRIKE_LIMIT) begin
              // killed slots keep their stale time and die again next check
              v.kill[i]     = 1'b1;
              v.ok          = 1'b0;
              wd_kill_count = wd_kill_count + 32'd1;
            end else begin
              v.warn[i]       = 1'b1;
              wd_last_tick[i] = it.now;
            end
          end
        end
      end
    endcase
    v.total = wd_kill_count;
  endtask

  // Offer one item and wait for it to be taken
  task automatic offer_item(input wd_item_t it, input logic fixed, input wd_verdict_t fv);
    wd_verdict_t pv;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    op_i          <= it.op;
    slot_i        <= it.slot;
    has_current_i <= it.has_cur;
    enable_i      <= it.en;
    now_i         <= it.now;
    do @(posedge clk_i); while (in_stall_o);
    predict_watchdog(it, pv);
    pending_verdicts.push_back(fixed ? fv : pv);
    n_items++;
    if (it.op == OP_CHECK) n_checks++;
  endtask

  task automatic idle_input(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Drain all results, then let the block settle before touching the register
  task automatic wait_drained();
    idle_input(1);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TIMEOUT;
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    wd_timeout = val;
    n_settings++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic add_row(input op_e op, input logic [3:0] slot, input logic hc,
                         input logic en, input logic [31:0] now, input logic fixed,
                         input logic [15:0] kill, input logic [15:0] warn,
                         input logic ok, input logic [31:0] total);
    wd_row_t r;
    r.it.op      = op;
    r.it.slot    = slot;
    r.it.has_cur = hc;
    r.it.en      = en;
    r.it.now     = now;
    r.fixed      = fixed;
    r.v.kill     = kill;
    r.v.warn     = warn;
    r.v.ok       = ok;
    r.v.total    = total;
    directed_rows.push_back(r);
  endtask

  // Random item: time mostly advances by amounts scaled to the timeout
  function automatic wd_item_t make_item(inout logic [31:0] clock_now);
    wd_item_t    it;
    int unsigned r;
    logic [31:0] short_step;
    logic [31:0] long_step;
    short_step = wd_timeout / 2 + 32'd1;
    long_step  = (wd_timeout > 32'h7FFF_FFFE) ? 32'hFFFF_FFFF : 2 * wd_timeout + 32'd2;
    r = $urandom_range(0, 19);
    if (r < 12)      clock_now = clock_now + $urandom_range(0, short_step);
    else if (r < 19) clock_now = clock_now + $urandom_range(0, long_step);
    else             clock_now = $urandom;
    r = $urandom_range(0, 99);
    if (r < 30)      it.op = OP_TICK;
    else if (r < 45) it.op = OP_PET;
    else if (r < 62) it.op = OP_ENABLE;
    else             it.op = OP_CHECK;
    it.slot    = 4'($urandom_range(0, NSLOTS - 1));
    it.has_cur = ($urandom_range(0, 9) != 0);
    it.en      = ($urandom_range(0, 3) != 0);
    // occasional noise: a time far off the running clock
    it.now     = ($urandom_range(0, 24) == 0) ? $urandom : clock_now;
    return it;
  endfunction

  // Result checking
  always @(posedge clk_i) begin
    wd_verdict_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      n_kill_bits += $countones(kill_mask_o);
      n_warn_bits += $countones(warn_mask_o);
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result", '0, {16'h0, kill_mask_o});
      end else begin
        e = pending_verdicts.pop_front();
        if (kill_mask_o !== e.kill)     report_mismatch("kill_mask", e.kill, kill_mask_o);
        if (warn_mask_o !== e.warn)     report_mismatch("warn_mask", e.warn, warn_mask_o);
        if (all_ok_o !== e.ok)          report_mismatch("all_ok", e.ok, all_ok_o);
        if (kills_total_o !== e.total)  report_mismatch("kills_total", e.total, kills_total_o);
      end
    end
  end

  // Hang detection: cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver stall bursts, plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk_i);
      end
    end
  end

  // Main sequence
  initial begin
    wd_item_t    it;
    wd_verdict_t none;
    logic [31:0] clock_now;
    logic [31:0] phase_timeout [6];

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = OP_TICK;
    slot_i        = '0;
    has_current_i = 1'b0;
    enable_i      = 1'b0;
    now_i         = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    err_count     = 0;
    n_items       = 0;
    n_checks      = 0;
    n_results     = 0;
    n_kill_bits   = 0;
    n_warn_bits   = 0;
    n_settings    = 1;
    quiet_cycles  = 0;
    none          = '{kill: '0, warn: '0, ok: 1'b1, total: '0};

    for (int i = 0; i < NSLOTS; i++) begin
      wd_enabled[i]   = 1'b0;
      wd_last_tick[i] = '0;
      wd_strikes[i]   = '0;
    end
    wd_kill_count = '0;
    wd_timeout    = TIMEOUT_RST;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, reset timeout of 500
    //       op          slot   hc    en    now           fix   kill     warn     ok    total
    add_row(OP_CHECK,  4'd0,  1'b0, 1'b0, 32'd0,        1'b1, 16'h0,   16'h0,   1'b1, 32'd0);
    add_row(OP_TICK,   4'd0,  1'b1, 1'b0, 32'd100,      1'b1, 16'h0,   16'h0,   1'b1, 32'd0);
    add_row(OP_ENABLE, 4'd0,  1'b1, 1'b1, 32'd0,        1'b1, 16'h0,   16'h0,   1'b1, 32'd0);
    add_row(OP_ENABLE, 4'd1,  1'b1, 1'b1, 32'd0,        1'b0, 16'h0,   16'h0,   1'b1, 32'd0);
    add_row(OP_ENABLE, 4'd15, 1'b1, 1'b1, 32'd0,        1'b0, 16'h0,   16'h0,   1'b1, 32'd0);
    // idle exactly at the timeout earns nothing, one tick past it warns
    add_row(OP_CHECK,  4'd0,  1'b1, 1'b0, 32'd500,      1'b1, 16'h0,   16'h0,   1'b1, 32'd0);
    add_row(OP_CHECK,  4'd0,  1'b1, 1'b0, 32'd501,      1'b1, 16'h0,   16'h8002, 1'b1, 32'd0);
    add_row(OP_PET,    4'd1,  1'b1, 1'b0, 32'd501,      1'b0, 16'h0,   16'h0,   1'b1, 32'd0);
    add_row(OP_TICK,   4'd15, 1'b1, 1'b0, 32'd600,      1'b0, 16'h0,   16'h0,   1'b1, 32'd0);
    // strikes build up to kills; no current task means slot 0 is checked
    add_row(OP_CHECK,  4'd0,  1'b0, 1'b0, 32'd1200,     1'b0, 16'h0,   16'h0,   1'b1, 32'd0);
    add_row(OP_CHECK,  4'd0,  1'b1, 1'b0, 32'd1800,     1'b0, 16'h0,   16'h0,   1'b1, 32'd0);
    add_row(OP_CHECK,  4'd0,  1'b1, 1'b1, 32'd2400,     1'b0, 16'h0,   16'h0,   1'b1, 32'd0);
    add_row(OP_ENABLE, 4'd15, 1'b1, 1'b0, 32'd0,        1'b0, 16'h0,   16'h0,   1'b1, 32'd0);
    // no current task, or a disabled slot: single-slot ops do nothing
    add_row(OP_TICK,   4'd3,  1'b0, 1'b1, 32'd7,        1'b0, 16'h0,   16'h0,   1'b1, 32'd0);
    add_row(OP_ENABLE, 4'd3,  1'b0, 1'b1, 32'd7,        1'b0, 16'h0,   16'h0,   1'b1, 32'd0);
    add_row(OP_PET,    4'd5,  1'b1, 1'b1, 32'd9,        1'b0, 16'h0,   16'h0,   1'b1, 32'd0);
    // time wraps past 2^32
    add_row(OP_ENABLE, 4'd7,  1'b1, 1'b1, 32'hFFFF_FFF0, 1'b0, 16'h0,  16'h0,   1'b1, 32'd0);
    add_row(OP_CHECK,  4'd2,  1'b1, 1'b0, 32'h0000_0010, 1'b0, 16'h0,  16'h0,   1'b1, 32'd0);
    add_row(OP_CHECK,  4'd15, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 16'h0,  16'h0,   1'b1, 32'd0);
    add_row(OP_PET,    4'd0,  1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 16'h0,  16'h0,   1'b1, 32'd0);
    // re-enabling a killed slot revives it
    add_row(OP_ENABLE, 4'd1,  1'b1, 1'b1, 32'hAAAA_5555, 1'b0, 16'h0,  16'h0,   1'b1, 32'd0);
    add_row(OP_CHECK,  4'd10, 1'b1, 1'b0, 32'h5555_AAAA, 1'b0, 16'h0,  16'h0,   1'b1, 32'd0);
    add_row(OP_CHECK,  4'd10, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, 16'h0,  16'h0,   1'b1, 32'd0);

    foreach (directed_rows[k]) begin
      if (k % 3 == 1) idle_input($urandom_range(1, 12));
      offer_item(directed_rows[k].it, directed_rows[k].fixed, directed_rows[k].v);
    end

    // Random phases over a range of timeouts, extremes included
    phase_timeout[0] = 32'd500;
    phase_timeout[1] = 32'd1;
    phase_timeout[2] = 32'hFFFF_FFFF;
    phase_timeout[3] = 32'd37;
    phase_timeout[4] = $urandom_range(2, 5000);
    phase_timeout[5] = $urandom_range(100, 1000);
    clock_now = $urandom;
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_timeout(phase_timeout[p]);
      calm = (p == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 100) hold_req = 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) idle_input($urandom_range(1, 12));
        it = make_item(clock_now);
        offer_item(it, 1'b0, none);
      end
    end

    // Wrap-up
    idle_input(1);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (pending_verdicts.size() != 0) report_mismatch("missing results", '0,
                                                      pending_verdicts.size());
    $display("Covered %0d items (%0d checks) under %0d timeout settings; %0d results compared.",
             n_items, n_checks, n_settings, n_results);
    $display("Results reported %0d slot kills and %0d warnings; %0d mismatches.",
             n_kill_bits, n_warn_bits, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
